### hdl/wtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared constants, types and helpers of the round-robin word tokenizer.
// ----------------------------------------------------------------------------
package wtr_pkg;

    localparam int MAX_WORD  = 40;
    localparam int MAX_LANES = 16;
    localparam int MIN_KEEP  = 3;

    localparam int LEN_W    = 6;
    localparam int LANE_W   = 4;
    localparam int LCNT_W   = 5;
    localparam int BYTE_W   = 8;
    localparam int LETTER_W = 7;

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    typedef enum logic {
        OP_STORE,
        OP_FLUSH
    } cmd_op_t;

    // STORE: idx is the buffer slot, emit starts a word of idx+1 letters.
    // FLUSH: idx is the word length, clr_lane resets the lane pointer.
    typedef struct packed {
        cmd_op_t              op;
        logic [LETTER_W-1:0]  letter;
        logic [LEN_W-1:0]     idx;
        logic                 emit;
        logic                 clr_lane;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    // lane count as used: zero means one, large values saturate
    function automatic logic [LCNT_W-1:0] eff_lanes(input logic [LCNT_W-1:0] cnt);
        logic [LCNT_W-1:0] n;
        begin
            if (cnt == '0)
                n = LCNT_W'(1);
            else if (cnt > LCNT_W'(MAX_LANES))
                n = LCNT_W'(MAX_LANES);
            else
                n = cnt;
            return n;
        end
    endfunction

endpackage

### hdl/wtr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtr_front
// Classifies text bytes, tracks word length and skip state, issues commands.
// ----------------------------------------------------------------------------
module wtr_front
    import wtr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              full,
    output logic              cmd_push,
    output cmd_t              cmd
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             skip_reg, skip_next;
    logic             accept;
    logic             is_letter;
    logic             cmd_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign is_letter = (text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign cmd_push = accept && cmd_valid;

    always_comb
    begin
        len_next      = len_reg;
        skip_next     = skip_reg;
        cmd_valid     = 1'b0;
        cmd.op        = OP_FLUSH;
        cmd.letter    = text_byte[LETTER_W-1:0] | LETTER_W'(8'h20);
        cmd.idx       = len_reg;
        cmd.emit      = (len_reg > LEN_W'(MIN_KEEP));
        cmd.clr_lane  = 1'b0;
        if (end_of_text)
        begin
            cmd_valid    = 1'b1;
            cmd.clr_lane = 1'b1;
            len_next     = '0;
            skip_next    = 1'b0;
        end
        else if (is_letter)
        begin
            if (!skip_reg)
            begin
                cmd_valid = 1'b1;
                cmd.op    = OP_STORE;
                if (len_reg + LEN_W'(1) == LEN_W'(MAX_WORD))
                begin
                    // word is full: send it now, drop the rest of the run
                    cmd.emit  = 1'b1;
                    len_next  = '0;
                    skip_next = 1'b1;
                end
                else
                begin
                    cmd.emit = 1'b0;
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
        else
        begin
            skip_next = 1'b0;
            len_next  = '0;
            cmd_valid = (len_reg > LEN_W'(MIN_KEEP));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else if (accept)
        begin
            len_reg  <= len_next;
            skip_reg <= skip_next;
        end
    end

endmodule

### hdl/wtr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtr_cmd_fifo
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module wtr_cmd_fifo
    import wtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CQ_CNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + CQ_PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + CQ_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### hdl/wtr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtr_back
// Word buffer, lane selection and letter-by-letter emission.
// ----------------------------------------------------------------------------
module wtr_back
    import wtr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    input  logic                cfg_wr_en,
    input  logic [LCNT_W-1:0]   cfg_wr_data,
    output logic [LCNT_W-1:0]   lanes_used,
    output logic                empty,
    input  logic                pop,
    output logic [LETTER_W-1:0] letter,
    output logic [LANE_W-1:0]   lane,
    output logic                word_end
);

    logic [LETTER_W-1:0] word_mem [MAX_WORD];

    back_state_t         state_reg, state_next;
    logic [LCNT_W-1:0]   lane_count_reg;
    logic [LANE_W-1:0]   lane_ptr_reg, lane_ptr_next;
    logic [LANE_W-1:0]   word_lane_reg, word_lane_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] letter_reg;
    logic [LANE_W-1:0]   lane_reg;
    logic                end_reg;
    logic                mem_we;
    logic                rd_en;
    logic                rd_last;
    logic [LCNT_W-1:0]   n_lanes;
    logic [LANE_W-1:0]   cur_lane;
    logic [LCNT_W-1:0]   lane_inc;
    logic [LANE_W-1:0]   adv_lane;
    logic                out_free;

    assign n_lanes    = eff_lanes(lane_count_reg);
    assign lanes_used = n_lanes;
    // pointer left beyond a lowered lane count falls back to lane 0
    assign cur_lane   = ({1'b0, lane_ptr_reg} < n_lanes) ? lane_ptr_reg : '0;
    assign lane_inc   = {1'b0, cur_lane} + LCNT_W'(1);
    assign adv_lane   = (lane_inc >= n_lanes) ? '0 : lane_inc[LANE_W-1:0];
    assign out_free   = !out_valid_reg || pop;
    assign rd_last    = (idx_reg + LEN_W'(1) == len_reg);

    assign empty    = !out_valid_reg;
    assign letter   = letter_reg;
    assign lane     = lane_reg;
    assign word_end = end_reg;

    always_comb
    begin
        state_next     = state_reg;
        lane_ptr_next  = lane_ptr_reg;
        word_lane_next = word_lane_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.op == OP_STORE)
                        mem_we = 1'b1;
                    if (q_cmd.emit)
                    begin
                        len_next       = (q_cmd.op == OP_STORE) ? q_cmd.idx + LEN_W'(1)
                                                                : q_cmd.idx;
                        idx_next       = '0;
                        word_lane_next = cur_lane;
                        lane_ptr_next  = q_cmd.clr_lane ? '0 : adv_lane;
                        state_next     = BK_EMIT;
                    end
                    else if (q_cmd.clr_lane)
                    begin
                        lane_ptr_next = '0;
                    end
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    rd_en          = 1'b1;
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + LEN_W'(1);
                    if (rd_last)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            lane_count_reg <= LCNT_W'(1);
            lane_ptr_reg   <= '0;
            word_lane_reg  <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lane_ptr_reg   <= lane_ptr_next;
            word_lane_reg  <= word_lane_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                lane_count_reg <= cfg_wr_data;
        end
    end

    // word buffer; read data lands straight in the output register
    always_ff @(posedge clk)
    begin
        if (mem_we)
            word_mem[q_cmd.idx] <= q_cmd.letter;
        if (rd_en)
        begin
            letter_reg <= word_mem[idx_reg];
            lane_reg   <= word_lane_reg;
            end_reg    <= rd_last;
        end
    end

endmodule

### hdl/word_tokenizer_round_robin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_tokenizer_round_robin
// Splits a byte stream into lower-case words and deals them over lanes.
// ----------------------------------------------------------------------------
// Input queue: push/full carries one text byte and an end_of_text mark per
//   transaction. Letters are buffered; a non-letter or end_of_text closes the
//   word, and words of four or more letters are sent. A run reaching 40
//   letters is sent at once and the rest of the run is skipped.
// Output queue: empty/pop; each transaction is one letter with its lane and a
//   word_end mark on the final letter.
// Config: cfg_wr_en/cfg_wr_data write lane_count (0 acts as 1, above 16 as 16);
//   write only while the block is idle.
// Timing: a byte is taken into a two-entry command queue; the back end pulls
//   one command per cycle while idle, then streams a word out at one letter
//   per cycle unless the output stalls, set by the single read port of the
//   word buffer. The first letter follows via the command queue and the emit
//   state. Bytes are taken at one per cycle while the queue has room; during
//   a burst of n letters the input stalls after the queue fills.
// Reset: clears word length, skip flag, lane pointer and both queues; sets
//   lane_count to 1. end_of_text clears the same word state after its flush.
// Output stall: the output register holds; the back end and then the input
//   queue back up.
// ----------------------------------------------------------------------------
module word_tokenizer_round_robin
    import wtr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [BYTE_W-1:0]   text_byte,
    input  logic                end_of_text,
    output logic                empty,
    input  logic                pop,
    output logic [LETTER_W-1:0] letter,
    output logic [LANE_W-1:0]   lane,
    output logic                word_end,
    input  logic                cfg_wr_en,
    input  logic [LCNT_W-1:0]   cfg_wr_data
);

    cmd_t              f_cmd;
    cmd_t              q_cmd;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [LCNT_W-1:0] lanes_used;

    wtr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .full        (full),
        .cmd_push    (q_push),
        .cmd         (f_cmd)
    );

    wtr_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (f_cmd),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    wtr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .lanes_used  (lanes_used),
        .empty       (empty),
        .pop         (pop),
        .letter      (letter),
        .lane        (lane),
        .word_end    (word_end)
    );

    a_lane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, lane} < lanes_used))
        else $error("output lane beyond lane count");

    a_letter_lower: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (letter >= LETTER_W'(97) && letter <= LETTER_W'(122)))
        else $error("output letter is not lower case");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin word tokenizer.
// ----------------------------------------------------------------------------
// A queue of text bytes feeds a clocked driver that pushes in random bursts.
// Each accepted transaction runs through a local tokenizer model that queues
// the letters it should produce. A clocked monitor pops on a rotating stall
// pattern and checks each letter, lane and word_end against the oldest entry.
// The lane count is rewritten between phases, including zero, saturating
// values and drops below the current lane pointer.
// ----------------------------------------------------------------------------
module tb_top;
    import wtr_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              eot;
    } text_item_t;

    typedef struct {
        logic [LETTER_W-1:0] letter;
        logic [LANE_W-1:0]   lane;
        logic                last;
    } letter_rec_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [BYTE_W-1:0]   text_byte = '0;
    logic                end_of_text = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [LETTER_W-1:0] letter;
    logic [LANE_W-1:0]   lane;
    logic                word_end;
    logic                cfg_wr_en = 1'b0;
    logic [LCNT_W-1:0]   cfg_wr_data = '0;

    text_item_t  text_feed[$];
    letter_rec_t expected_letters[$];
    int          err_count = 0;

    // tokenizer model state
    logic [LETTER_W-1:0] word_buf[MAX_WORD];
    int                  word_len = 0;
    int                  next_lane = 0;
    bit                  skipping = 1'b0;
    logic [LCNT_W-1:0]   lanes_cfg = LCNT_W'(1);

    // driver burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall pattern
    logic [15:0] pop_pattern = 16'hFFFF;
    int          pattern_left = 0;

    word_tokenizer_round_robin DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .letter      (letter),
        .lane        (lane),
        .word_end    (word_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic bit is_letter(logic [BYTE_W-1:0] ch);
        return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
    endfunction

    // send the buffered word to the current lane, then advance the pointer
    function automatic void send_word();
        int          n;
        int          ln;
        int          i;
        letter_rec_t rec;
        n = (lanes_cfg == 0) ? 1 : ((lanes_cfg > MAX_LANES) ? MAX_LANES : int'(lanes_cfg));
        ln = (next_lane < n) ? next_lane : 0;
        for (i = 0; i < word_len; i++)
        begin
            rec.letter = word_buf[i];
            rec.lane   = ln[LANE_W-1:0];
            rec.last   = (i == word_len - 1);
            expected_letters.push_back(rec);
        end
        next_lane = (ln + 1 >= n) ? 0 : ln + 1;
        word_len = 0;
    endfunction

    function automatic void tokenize_byte(text_item_t it);
        if (it.eot)
        begin
            if (word_len > MIN_KEEP)
                send_word();
            word_len = 0;
            next_lane = 0;
            skipping = 1'b0;
        end
        else if (is_letter(it.ch))
        begin
            if (!skipping)
            begin
                if (word_len >= MAX_WORD)
                    word_len = 0;
                word_buf[word_len] = LETTER_W'(it.ch | 8'h20);
                word_len++;
                // full-length word goes out now, rest of the run is dropped
                if (word_len == MAX_WORD)
                begin
                    send_word();
                    skipping = 1'b1;
                end
            end
        end
        else
        begin
            skipping = 1'b0;
            if (word_len > MIN_KEEP)
                send_word();
            word_len = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t MISMATCH %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void add_item(logic [BYTE_W-1:0] ch, logic eot);
        text_item_t it;
        it.ch  = ch;
        it.eot = eot;
        text_feed.push_back(it);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_delim();
        logic [BYTE_W-1:0] ch;
        ch = BYTE_W'($urandom_range(0, 255));
        while (is_letter(ch))
            ch = BYTE_W'($urandom_range(0, 255));
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_letter();
        return BYTE_W'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
    endfunction

    // mostly well-formed words with random content, some noise bytes
    function automatic void queue_text(int budget);
        int sel;
        int len;
        int i;
        while (budget > 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                add_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                budget--;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    len = $urandom_range(1, 8);
                else if (sel < 80)
                    len = $urandom_range(3, 4);
                else if (sel < 92)
                    len = $urandom_range(9, 20);
                else
                    len = $urandom_range(MAX_WORD - 2, MAX_WORD + 6);
                for (i = 0; i < len; i++)
                    add_item(pick_letter(), 1'b0);
                if ($urandom_range(0, 99) < 6)
                    add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
                else
                    add_item(pick_delim(), 1'b0);
                budget -= len + 1;
            end
        end
    endfunction

    // wait for the feed and expectations to drain, then let the pipe settle
    task automatic settle();
        @(negedge clk);
        while (text_feed.size() != 0 || push || expected_letters.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_lanes(logic [LCNT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        lanes_cfg = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        bit drive_now;
        if (!rst_n)
        begin
            push        <= 1'b0;
            text_byte   <= '0;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (push && !full)
                tokenize_byte(text_feed.pop_front());
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                drive_now = 1'b0;
            end
            else
            begin
                burst_left--;
                drive_now = (text_feed.size() > 0);
            end
            push <= drive_now;
            if (drive_now)
            begin
                text_byte   <= text_feed[0].ch;
                end_of_text <= text_feed[0].eot;
            end
        end
    end

    // monitor: pops on a rotating pattern, checks every transaction taken
    always @(posedge clk or negedge rst_n)
    begin
        letter_rec_t exp_rec;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_letters.size() == 0)
                    report_mismatch($sformatf("unexpected letter 0x%0h lane %0d", letter, lane));
                else
                begin
                    exp_rec = expected_letters.pop_front();
                    if (letter !== exp_rec.letter)
                        report_mismatch($sformatf("letter 0x%0h, want 0x%0h",
                                                  letter, exp_rec.letter));
                    if (lane !== exp_rec.lane)
                        report_mismatch($sformatf("lane %0d, want %0d", lane, exp_rec.lane));
                    if (word_end !== exp_rec.last)
                        report_mismatch($sformatf("word_end %0b, want %0b",
                                                  word_end, exp_rec.last));
                end
            end
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pop_pattern = 16'hFFFF;
                    1: pop_pattern = 16'($urandom);
                    2: pop_pattern = 16'h0101;
                    default: pop_pattern = 16'hF0F0;
                endcase
                pattern_left = $urandom_range(16, 80);
            end
            pattern_left--;
            pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
            pop <= pop_pattern[0];
        end
    end

    initial
    begin
        logic [LCNT_W-1:0] lane_plan[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: case and range edges, short word drop, end-of-text flush
        @(negedge clk);
        add_item("A", 1'b0);
        add_item("z", 1'b0);
        add_item("Z", 1'b0);
        add_item("a", 1'b0);
        add_item(8'h40, 1'b0);
        add_item("a", 1'b0);
        add_item("b", 1'b0);
        add_item("c", 1'b0);
        add_item(8'h5B, 1'b0);
        add_item("y", 1'b0);
        add_item("Y", 1'b0);
        add_item("y", 1'b0);
        add_item("Y", 1'b0);
        add_item("y", 1'b0);
        add_item(8'h60, 1'b0);
        add_item("q", 1'b0);
        add_item("Q", 1'b0);
        add_item("q", 1'b0);
        add_item("q", 1'b0);
        add_item("x", 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'h7B, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        settle();

        // lane count drops below a live pointer: 16 -> 0, 17 -> 2
        lane_plan = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd2, 5'd1, 5'd5};
        lane_plan.push_back(LCNT_W'($urandom_range(0, 31)));
        foreach (lane_plan[p])
        begin
            write_lanes(lane_plan[p]);
            @(negedge clk);
            queue_text(30);
            settle();
        end

        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
